### hdl/ssp_pkg.sv
// shared types and constants of the shortest path engine
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

  localparam int NODE_W    = 10;
  localparam int WPORT_W   = 16;
  localparam int DIST_W    = 26;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int NCNT_W    = 11;
  localparam int CFG_IDX_W = 1;
  localparam int RES_W     = 3;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADNODE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE     = 1'b1;

  localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 11'd1024;

  localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_SAT = {{(DIST_W-1){1'b1}}, 1'b0};

  // result kinds
  localparam logic [RES_W-1:0] RES_ADD     = 3'd0;
  localparam logic [RES_W-1:0] RES_CLEAR   = 3'd1;
  localparam logic [RES_W-1:0] RES_RUN_OK  = 3'd2;
  localparam logic [RES_W-1:0] RES_RUN_BAD = 3'd3;
  localparam logic [RES_W-1:0] RES_QUERY   = 3'd4;

  typedef struct packed {
    logic             add_edge;
    logic             clr_edges;
    logic             q_read;
    logic             sweep_start;
    logic             sweep_step;
    logic             seed;
    logic             fifo_rd;
    logic             pop;
    logic             du_load;
    logic             edge_rd;
    logic             relax_rd;
    logic             relax_wr;
    logic             res_en;
    logic [RES_W-1:0] res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic src_bad;
    logic fifo_empty;
    logic scan_done;
    logic edge_match;
  } dp_stat_t;

endpackage

`default_nettype wire

### hdl/ssp_ctrl.sv
// controller state machine of the shortest path engine
`timescale 1ns / 1ps
`default_nettype none

module ssp_ctrl (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire  [ssp_pkg::CMD_W-1:0]    cmd,
  input  ssp_pkg::dp_stat_t            stat,
  output ssp_pkg::dp_cmd_t             ctl,
  output logic                         busy
);
  import ssp_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_QRES  = 4'd2;
  localparam logic [3:0] S_CLEAR = 4'd3;
  localparam logic [3:0] S_SEED  = 4'd4;
  localparam logic [3:0] S_POP   = 4'd5;
  localparam logic [3:0] S_POP2  = 4'd6;
  localparam logic [3:0] S_POP3  = 4'd7;
  localparam logic [3:0] S_SCAN  = 4'd8;
  localparam logic [3:0] S_EDGE  = 4'd9;
  localparam logic [3:0] S_REL   = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        ctl.sweep_step = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          case (cmd)
            CMD_ADD: begin
              ctl.add_edge = 1'b1;
              ctl.res_en   = 1'b1;
              ctl.res_sel  = RES_ADD;
            end
            CMD_CLEAR: begin
              ctl.clr_edges = 1'b1;
              ctl.res_en    = 1'b1;
              ctl.res_sel   = RES_CLEAR;
            end
            CMD_QUERY: begin
              ctl.q_read = 1'b1;
              state_next = S_QRES;
            end
            CMD_RUN: begin
              ctl.sweep_start = 1'b1;
              state_next      = S_CLEAR;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_QRES: begin
        ctl.res_en  = 1'b1;
        ctl.res_sel = RES_QUERY;
        state_next  = S_IDLE;
      end
      S_CLEAR: begin
        ctl.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          if (stat.src_bad) begin
            ctl.res_en  = 1'b1;
            ctl.res_sel = RES_RUN_BAD;
            state_next  = S_IDLE;
          end else begin
            state_next = S_SEED;
          end
        end
      end
      S_SEED: begin
        ctl.seed   = 1'b1;
        state_next = S_POP;
      end
      S_POP: begin
        if (stat.fifo_empty) begin
          ctl.res_en  = 1'b1;
          ctl.res_sel = RES_RUN_OK;
          state_next  = S_IDLE;
        end else begin
          ctl.fifo_rd = 1'b1;
          state_next  = S_POP2;
        end
      end
      S_POP2: begin
        ctl.pop    = 1'b1;
        state_next = S_POP3;
      end
      S_POP3: begin
        ctl.du_load = 1'b1;
        state_next  = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_POP;
        end else begin
          ctl.edge_rd = 1'b1;
          state_next  = S_EDGE;
        end
      end
      S_EDGE: begin
        if (stat.edge_match) begin
          ctl.relax_rd = 1'b1;
          state_next   = S_REL;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_REL: begin
        ctl.relax_wr = 1'b1;
        state_next   = S_SCAN;
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

`default_nettype wire

### hdl/ssp_dp.sv
// datapath of the shortest path engine: edge store, distances, queue, results
`timescale 1ns / 1ps
`default_nettype none

module ssp_dp #(
  parameter int MAX_NODES   = 1024,
  parameter int MAX_EDGES   = 4096,
  parameter int WEIGHT_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  ssp_pkg::dp_cmd_t                 ctl,
  output ssp_pkg::dp_stat_t                stat,
  input  wire  [ssp_pkg::NODE_W-1:0]       from_node,
  input  wire  [ssp_pkg::NODE_W-1:0]       to_node,
  input  wire  [ssp_pkg::WPORT_W-1:0]      weight,
  input  wire                              cfg_wr,
  input  wire  [ssp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [ssp_pkg::NCNT_W-1:0]       cfg_data,
  output logic                             done,
  output logic [ssp_pkg::STAT_W-1:0]       status,
  output logic [ssp_pkg::NODE_W-1:0]       node,
  output logic [ssp_pkg::DIST_W-1:0]       distance,
  output logic                             reachable
);
  import ssp_pkg::*;

  localparam int NAW     = $clog2(MAX_NODES);
  localparam int FCW     = $clog2(MAX_NODES + 1);
  localparam int EAW     = $clog2(MAX_EDGES);
  localparam int ETW     = $clog2(MAX_EDGES + 1);
  localparam int EDGE_W  = 2 * NODE_W + WEIGHT_BITS;
  localparam int SUM_W   = ((DIST_W > WEIGHT_BITS) ? DIST_W : WEIGHT_BITS) + 1;
  localparam int LIM_CAP = (MAX_NODES < 2047) ? MAX_NODES : 2047;

  // configuration
  logic [NCNT_W-1:0] node_count;
  logic [NODE_W-1:0] source_node;
  logic [NCNT_W-1:0] lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= NODE_COUNT_RST;
      source_node <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_NODE_COUNT: node_count  <= cfg_data;
        REG_SOURCE:     source_node <= cfg_data[NODE_W-1:0];
        default:        node_count  <= node_count;
      endcase
    end
  end

  assign lim = (int'(node_count) < LIM_CAP) ? node_count : NCNT_W'(LIM_CAP);

  // edge store
  logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
  logic [EDGE_W-1:0] edge_rdata;
  logic [ETW-1:0]    edge_total;
  logic [ETW-1:0]    scan_k;
  logic              add_bad;
  logic              add_full;
  logic              add_ok;
  logic [NODE_W-1:0] e_tail;
  logic [NODE_W-1:0] e_head;
  logic [WEIGHT_BITS-1:0] e_wt;

  assign add_bad  = ({1'b0, from_node} >= lim) || ({1'b0, to_node} >= lim);
  assign add_full = (edge_total == ETW'(MAX_EDGES));
  assign add_ok   = ctl.add_edge && !add_bad && !add_full;

  always_ff @(posedge clk) begin
    if (add_ok) begin
      edge_mem[edge_total[EAW-1:0]] <= {from_node, to_node, WEIGHT_BITS'(weight)};
    end
    if (ctl.edge_rd) begin
      edge_rdata <= edge_mem[scan_k[EAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total <= '0;
    end else if (ctl.clr_edges) begin
      edge_total <= '0;
    end else if (add_ok) begin
      edge_total <= edge_total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.du_load) begin
      scan_k <= '0;
    end else if (ctl.edge_rd) begin
      scan_k <= scan_k + 1'b1;
    end
  end

  assign e_tail = edge_rdata[EDGE_W-1 -: NODE_W];
  assign e_head = edge_rdata[WEIGHT_BITS +: NODE_W];
  assign e_wt   = edge_rdata[WEIGHT_BITS-1:0];

  // walk registers
  logic [NODE_W-1:0] u_node;
  logic [NODE_W-1:0] v_node;
  logic [NODE_W-1:0] q_node;
  logic [DIST_W-1:0] du;
  logic [DIST_W-1:0] nd;
  logic [SUM_W-1:0]  sum;
  logic [DIST_W-1:0] nd_next;
  logic [NAW-1:0]    sweep_idx;

  assign sum     = SUM_W'(du) + SUM_W'(e_wt);
  assign nd_next = (sum >= SUM_W'(DIST_INF)) ? DIST_SAT : sum[DIST_W-1:0];

  // node queue
  logic [NODE_W-1:0] fifo_mem [MAX_NODES];
  logic [NODE_W-1:0] fifo_rdata;
  logic [NAW-1:0]    head;
  logic [NAW-1:0]    tail;
  logic [FCW-1:0]    fill;

  // distances and in-queue flags
  logic [DIST_W-1:0] dist_mem [MAX_NODES];
  logic              inq_mem  [MAX_NODES];
  logic [DIST_W-1:0] dist_rdata;
  logic              inq_rdata;
  logic [NAW-1:0]    dist_raddr;
  logic              improve;
  logic              do_push;
  logic [NODE_W-1:0] push_node;

  assign improve   = dist_rdata > nd;
  assign do_push   = ctl.seed || (ctl.relax_wr && improve && !inq_rdata);
  assign push_node = ctl.seed ? source_node : v_node;

  always_comb begin
    if (ctl.q_read) begin
      dist_raddr = NAW'(to_node);
    end else if (ctl.pop) begin
      dist_raddr = NAW'(fifo_rdata);
    end else begin
      dist_raddr = NAW'(e_head);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop)      u_node <= fifo_rdata;
    if (ctl.du_load)  du     <= dist_rdata;
    if (ctl.q_read)   q_node <= to_node;
    if (ctl.relax_rd) begin
      nd     <= nd_next;
      v_node <= e_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.sweep_start) begin
      sweep_idx <= '0;
    end else if (ctl.sweep_step) begin
      sweep_idx <= stat.sweep_last ? '0 : sweep_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    dist_rdata <= dist_mem[dist_raddr];
    inq_rdata  <= inq_mem[NAW'(e_head)];
    if (ctl.sweep_step) begin
      dist_mem[sweep_idx] <= DIST_INF;
      inq_mem[sweep_idx]  <= 1'b0;
    end else if (ctl.seed) begin
      dist_mem[NAW'(source_node)] <= '0;
      inq_mem[NAW'(source_node)]  <= 1'b1;
    end else if (ctl.pop) begin
      inq_mem[NAW'(fifo_rdata)] <= 1'b0;
    end else if (ctl.relax_wr && improve) begin
      dist_mem[NAW'(v_node)] <= nd;
      if (!inq_rdata) inq_mem[NAW'(v_node)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) fifo_mem[tail] <= push_node;
    if (ctl.fifo_rd) fifo_rdata <= fifo_mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.sweep_start) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == NAW'(MAX_NODES - 1)) ? '0 : tail + 1'b1;
      end
      if (ctl.pop) begin
        head <= (head == NAW'(MAX_NODES - 1)) ? '0 : head + 1'b1;
      end
      // push and pop never share a cycle
      if (do_push) begin
        fill <= fill + 1'b1;
      end else if (ctl.pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assign stat.sweep_last = (sweep_idx == NAW'(MAX_NODES - 1));
  assign stat.src_bad    = ({1'b0, source_node} >= lim);
  assign stat.fifo_empty = (fill == '0);
  assign stat.scan_done  = (scan_k == edge_total);
  assign stat.edge_match = (e_tail == u_node) && ({1'b0, e_head} >= lim) == 1'b0;

  // result register
  logic q_bad;
  assign q_bad = ({1'b0, q_node} >= lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.res_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_en) begin
      status    <= ST_OK;
      node      <= '0;
      distance  <= '0;
      reachable <= 1'b0;
      case (ctl.res_sel)
        RES_ADD: begin
          if (add_bad) begin
            status <= ST_BADNODE;
          end else if (add_full) begin
            status <= ST_FULL;
          end
        end
        RES_RUN_BAD: status <= ST_BADNODE;
        RES_QUERY: begin
          node <= q_node;
          if (q_bad) begin
            status   <= ST_BADNODE;
            distance <= DIST_INF;
          end else begin
            distance  <= dist_rdata;
            reachable <= (dist_rdata != DIST_INF);
          end
        end
        default: status <= ST_OK;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/single_source_shortest_path_core.sv
// top level of the queue-driven shortest path engine
`timescale 1ns / 1ps
`default_nettype none

// Commands are taken when start is high and busy is low; each gives exactly one
// result, shown for one cycle with done high, which the receiver must take then.
// Add edge and clear edges leave busy low, may follow each other every cycle and
// give their result in the next cycle; a query does one registered read of the
// distance memory, then passes S_QRES. A run sweeps the distance and in-queue
// memories; a source out of range then ends it with a bad-node result, else it
// seeds the source and walks the queue: each popped node scans every stored edge
// through the single read port, with a relax step per matching out-edge, and the
// run ends once the queue is found empty. After reset the same sweep runs with
// busy high. Configuration writes are always ready and go to the node count
// (index 0) or the source node (index 1).

module single_source_shortest_path_core #(
  parameter int MAX_NODES   = 1024,
  parameter int MAX_EDGES   = 4096,
  parameter int WEIGHT_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  wire  [ssp_pkg::CMD_W-1:0]        cmd,
  input  wire  [ssp_pkg::NODE_W-1:0]       from_node,
  input  wire  [ssp_pkg::NODE_W-1:0]       to_node,
  input  wire  [ssp_pkg::WPORT_W-1:0]      weight,
  output logic                             done,
  output logic [ssp_pkg::STAT_W-1:0]       status,
  output logic [ssp_pkg::NODE_W-1:0]       node,
  output logic [ssp_pkg::DIST_W-1:0]       distance,
  output logic                             reachable,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [ssp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [ssp_pkg::NCNT_W-1:0]       cfg_data
);
  import ssp_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  ssp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  ssp_dp #(
    .MAX_NODES   (MAX_NODES),
    .MAX_EDGES   (MAX_EDGES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .from_node (from_node),
    .to_node   (to_node),
    .weight    (weight),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .status    (status),
    .node      (node),
    .distance  (distance),
    .reachable (reachable)
  );

  a_add_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == CMD_ADD || cmd == CMD_CLEAR)) |=> done)
    else $error("add or clear beat gave no result in the next cycle");

  a_query_two_cycles: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == CMD_QUERY) |=> (busy && !done) ##1 (done && !busy))
    else $error("query result not delivered two cycles after the beat");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_FULL || status == ST_BADNODE))
    else $error("result carries an undefined status code");

  a_reach_dist: assert property (@(posedge clk) disable iff (rst)
    (done && reachable) |-> (distance != DIST_INF && status == ST_OK))
    else $error("reachable node reported with infinite distance");

endmodule

`default_nettype wire

### verif/tb_single_source_shortest_path_core.sv
// testbench of the shortest path engine: directed table, edge store fill, random phases
`timescale 1ns / 1ps

module tb_single_source_shortest_path_core;
  import ssp_pkg::*;

  localparam int NODES = 1024;
  localparam int EDGES = 4096;
  localparam int IDLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1500;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [NODE_W-1:0] node;
    logic [DIST_W-1:0] distance;
    logic              reachable;
  } answer_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [NCNT_W-1:0]    reg_val;
    logic [CMD_W-1:0]     op;
    logic [NODE_W-1:0]    tail;
    logic [NODE_W-1:0]    head;
    logic [WPORT_W-1:0]   len;
    bit                   typed;
    answer_t              ans;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] cmd = CMD_QUERY;
  logic [NODE_W-1:0] from_node = '0;
  logic [NODE_W-1:0] to_node = '0;
  logic [WPORT_W-1:0] weight = '0;
  logic done;
  logic [STAT_W-1:0] status;
  logic [NODE_W-1:0] node;
  logic [DIST_W-1:0] distance;
  logic reachable;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_NODE_COUNT;
  logic [NCNT_W-1:0] cfg_data = '0;

  always #6 clk = ~clk;

  single_source_shortest_path_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .from_node(from_node), .to_node(to_node), .weight(weight), .done(done),
    .status(status), .node(node), .distance(distance), .reachable(reachable),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow state of the engine
  logic [NCNT_W-1:0]  shadow_count;
  logic [NODE_W-1:0]  shadow_source;
  logic [NODE_W-1:0]  edge_tail [EDGES];
  logic [NODE_W-1:0]  edge_head [EDGES];
  logic [WPORT_W-1:0] edge_len [EDGES];
  int                 edge_cnt;
  logic [DIST_W-1:0]  best_dist [NODES];
  bit                 waiting [NODES];

  answer_t   pending_answers[$];
  stim_row_t stim_table[$];
  int        errors = 0;
  int        idle_cycles = 0;
  int        random_sent = 0;
  bit        gaps_on = 1'b1;

  function automatic int nodes_live();
    return (shadow_count > NODES) ? NODES : int'(shadow_count);
  endfunction

  // queue-driven relaxation, out-edges taken in load order
  function automatic logic [STAT_W-1:0] shortest_walk();
    int lim;
    int u;
    int v;
    logic [DIST_W:0] cand;
    int work[$];
    lim = nodes_live();
    for (int i = 0; i < NODES; i++) begin
      best_dist[i] = DIST_INF;
      waiting[i] = 1'b0;
    end
    if (int'(shadow_source) >= lim) return ST_BADNODE;
    best_dist[shadow_source] = '0;
    work.insert(work.size(), int'(shadow_source));
    waiting[shadow_source] = 1'b1;
    while (work.size() > 0) begin
      u = work.pop_front();
      waiting[u] = 1'b0;
      for (int e = 0; e < edge_cnt; e++) begin
        if (edge_tail[e] == u && edge_tail[e] < lim && edge_head[e] < lim) begin
          v = edge_head[e];
          cand = {1'b0, best_dist[u]} + edge_len[e];
          if (cand >= {1'b0, DIST_INF}) cand = {1'b0, DIST_SAT};
          if ({1'b0, best_dist[v]} > cand) begin
            best_dist[v] = cand[DIST_W-1:0];
            if (!waiting[v] && work.size() < NODES) begin
              work.insert(work.size(), v);
              waiting[v] = 1'b1;
            end
          end
        end
      end
    end
    return ST_OK;
  endfunction

  function automatic answer_t predict_answer(logic [CMD_W-1:0] op, logic [NODE_W-1:0] tail,
                                             logic [NODE_W-1:0] head, logic [WPORT_W-1:0] len);
    answer_t a;
    int lim;
    lim = nodes_live();
    a = '{status: ST_OK, node: '0, distance: '0, reachable: 1'b0};
    case (op)
      CMD_ADD: begin
        if (tail >= lim || head >= lim) a.status = ST_BADNODE;
        else if (edge_cnt >= EDGES) a.status = ST_FULL;
        else begin
          edge_tail[edge_cnt] = tail;
          edge_head[edge_cnt] = head;
          edge_len[edge_cnt] = len;
          edge_cnt++;
        end
      end
      CMD_RUN: a.status = shortest_walk();
      CMD_QUERY: begin
        a.node = head;
        if (head >= lim) begin
          a.status = ST_BADNODE;
          a.distance = DIST_INF;
        end else begin
          a.distance = best_dist[head];
          a.reachable = (best_dist[head] != DIST_INF);
        end
      end
      default: edge_cnt = 0;
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          answer_t a;
          a = pending_answers.pop_front();
          if (status !== a.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, a.status));
          if (node !== a.node)
            report_mismatch($sformatf("node %0d, expected %0d", node, a.node));
          if (distance !== a.distance)
            report_mismatch($sformatf("distance %0d, expected %0d", distance, a.distance));
          if (reachable !== a.reachable)
            report_mismatch($sformatf("reachable %0b, expected %0b", reachable, a.reachable));
        end
      end
      if (done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_single_source_shortest_path_core: done, errors");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called at a rising edge; returns at the rising edge after the beat plus any gap
  task automatic send_command(logic [CMD_W-1:0] op, logic [NODE_W-1:0] tail,
                              logic [NODE_W-1:0] head, logic [WPORT_W-1:0] len,
                              bit typed, answer_t typed_ans);
    answer_t a;
    int gap;
    start <= 1'b1;
    cmd <= op;
    from_node <= tail;
    to_node <= head;
    weight <= len;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    a = predict_answer(op, tail, head, len);
    pending_answers.insert(pending_answers.size(), typed ? typed_ans : a);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_plain(logic [CMD_W-1:0] op, logic [NODE_W-1:0] tail,
                            logic [NODE_W-1:0] head, logic [WPORT_W-1:0] len);
    send_command(op, tail, head, len, 1'b0, '{ST_OK, '0, '0, 1'b0});
  endtask

  // only once all results are back
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [NCNT_W-1:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() > 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    if (idx == REG_NODE_COUNT) shadow_count = val;
    else shadow_source = val[NODE_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic row_item(logic [CMD_W-1:0] op, int tail, int head, int len);
    stim_row_t r;
    r = '{default: '0};
    r.op = op;
    r.tail = NODE_W'(tail);
    r.head = NODE_W'(head);
    r.len = WPORT_W'(len);
    stim_table.insert(stim_table.size(), r);
  endtask

  task automatic row_check(logic [CMD_W-1:0] op, int tail, int head, int len,
                           logic [STAT_W-1:0] st, int nd, logic [DIST_W-1:0] ds, bit rc);
    stim_row_t r;
    r = '{default: '0};
    r.op = op;
    r.tail = NODE_W'(tail);
    r.head = NODE_W'(head);
    r.len = WPORT_W'(len);
    r.typed = 1'b1;
    r.ans = '{st, nd[NODE_W-1:0], ds, rc};
    stim_table.insert(stim_table.size(), r);
  endtask

  task automatic row_reg(logic [CFG_IDX_W-1:0] idx, int val);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = NCNT_W'(val);
    stim_table.insert(stim_table.size(), r);
  endtask

  function automatic logic [NODE_W-1:0] pick_node(int lim);
    int r;
    r = $urandom_range(0, 99);
    if (lim == 0 || r < 8) return NODE_W'($urandom_range(0, NODES - 1));
    if (r < 70) return NODE_W'($urandom_range(0, ((lim < 16) ? lim : 16) - 1));
    return NODE_W'($urandom_range(0, lim - 1));
  endfunction

  function automatic logic [WPORT_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 6) return WPORT_W'($urandom_range(1, 20));
    return WPORT_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    int lim;
    int count_pick;
    int adds;
    int r;
    shadow_count = NODE_COUNT_RST;
    shadow_source = '0;
    edge_cnt = 0;
    for (int i = 0; i < NODES; i++) begin
      best_dist[i] = DIST_INF;
      waiting[i] = 1'b0;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: after reset, extremes, error codes
    row_check(CMD_QUERY, 0, 0, 0, ST_OK, 0, DIST_INF, 1'b0);
    row_check(CMD_QUERY, 1023, 1023, 0, ST_OK, 1023, DIST_INF, 1'b0);
    row_check(CMD_ADD, 0, 1, 0, ST_OK, 0, '0, 1'b0);
    row_check(CMD_ADD, 1023, 1023, 65535, ST_OK, 0, '0, 1'b0);
    row_item(CMD_ADD, 1, 2, 65535);
    row_item(CMD_ADD, 2, 1023, 1);
    row_check(CMD_RUN, 0, 0, 0, ST_OK, 0, '0, 1'b0);
    row_item(CMD_QUERY, 0, 2, 0);
    row_item(CMD_QUERY, 0, 1023, 0);
    row_check(CMD_QUERY, 0, 5, 0, ST_OK, 5, DIST_INF, 1'b0);
    row_check(CMD_CLEAR, 0, 0, 0, ST_OK, 0, '0, 1'b0);
    row_item(CMD_QUERY, 0, 2, 0);
    row_reg(REG_NODE_COUNT, 4);
    row_check(CMD_ADD, 0, 4, 9, ST_BADNODE, 0, '0, 1'b0);
    row_check(CMD_ADD, 4, 0, 9, ST_BADNODE, 0, '0, 1'b0);
    row_check(CMD_QUERY, 0, 4, 0, ST_BADNODE, 4, DIST_INF, 1'b0);
    row_reg(REG_SOURCE, 5);
    row_check(CMD_RUN, 0, 0, 0, ST_BADNODE, 0, '0, 1'b0);
    row_check(CMD_QUERY, 0, 0, 0, ST_OK, 0, DIST_INF, 1'b0);
    row_reg(REG_SOURCE, 3);
    row_item(CMD_ADD, 3, 1, 7);
    row_item(CMD_ADD, 1, 3, 2);
    row_item(CMD_ADD, 1, 0, 5);
    row_item(CMD_RUN, 0, 0, 0);
    row_item(CMD_QUERY, 0, 0, 0);
    row_check(CMD_QUERY, 0, 3, 0, ST_OK, 3, '0, 1'b1);
    row_reg(REG_NODE_COUNT, 0);
    row_check(CMD_QUERY, 0, 0, 0, ST_BADNODE, 0, DIST_INF, 1'b0);
    row_reg(REG_NODE_COUNT, 2047);
    row_item(CMD_QUERY, 0, 1023, 0);

    foreach (stim_table[i]) begin
      if (stim_table[i].is_cfg) write_register(stim_table[i].reg_idx, stim_table[i].reg_val);
      else send_command(stim_table[i].op, stim_table[i].tail, stim_table[i].head,
                        stim_table[i].len, stim_table[i].typed, stim_table[i].ans);
    end

    // fill the edge store on two nodes, then overflow it
    write_register(REG_NODE_COUNT, 2);
    write_register(REG_SOURCE, 0);
    gaps_on = 1'b0;
    send_plain(CMD_CLEAR, 0, 0, 0);
    for (int i = 0; i < EDGES; i++)
      send_plain(CMD_ADD, NODE_W'($urandom_range(0, 1)), NODE_W'($urandom_range(0, 1)),
                 pick_len());
    send_command(CMD_ADD, 0, 1, 3, 1'b1, '{ST_FULL, '0, '0, 1'b0});
    send_command(CMD_ADD, 5, 0, 3, 1'b1, '{ST_BADNODE, '0, '0, 1'b0});
    send_plain(CMD_RUN, 0, 0, 0);
    send_plain(CMD_QUERY, 0, 1, 0);
    send_plain(CMD_CLEAR, 0, 0, 0);

    // random phases: one node count and source each, mostly small graphs
    while (random_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 65) count_pick = $urandom_range(1, 16);
      else if (r < 80) count_pick = $urandom_range(17, 1023);
      else if (r < 92) count_pick = $urandom_range(1024, 2047);
      else if (r < 96) count_pick = 0;
      else count_pick = 1;
      write_register(REG_NODE_COUNT, NCNT_W'(count_pick));
      lim = nodes_live();
      if (lim > 0 && $urandom_range(0, 99) < 85)
        write_register(REG_SOURCE, NCNT_W'($urandom_range(0, ((lim < 16) ? lim : 16) - 1)));
      else write_register(REG_SOURCE, NCNT_W'($urandom_range(0, NODES - 1)));
      gaps_on = ($urandom_range(0, 3) != 0);
      send_plain(CMD_CLEAR, 0, 0, 0);
      adds = $urandom_range(1, 40);
      for (int i = 0; i < adds; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_plain(CMD_W'($urandom_range(0, 3)), NODE_W'($urandom_range(0, NODES - 1)),
                     NODE_W'($urandom_range(0, NODES - 1)), WPORT_W'($urandom_range(0, 65535)));
        else send_plain(CMD_ADD, pick_node(lim), pick_node(lim), pick_len());
      end
      send_plain(CMD_RUN, 0, 0, 0);
      for (int i = 0; i < 12; i++) begin
        r = $urandom_range(0, 29);
        if (r == 0) send_plain(CMD_RUN, 0, 0, 0);
        else if (r == 1) send_plain(CMD_ADD, pick_node(lim), pick_node(lim), pick_len());
        else send_plain(CMD_QUERY, NODE_W'($urandom_range(0, NODES - 1)), pick_node(lim), 0);
      end
      random_sent += adds + 14;
    end

    start <= 1'b0;
    while (pending_answers.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("tb_single_source_shortest_path_core: done, clean");
    end else begin
      $display("tb_single_source_shortest_path_core: done, errors");
    end
    $finish;
  end

endmodule
